// ----- rtl/slfr_pkg.sv -----
// Shared constants, types and the CRC-16/ARC byte update for the frame receiver.
package slfr_pkg;

    localparam int unsigned LENGTH_POSITION_DEF = 2;
    localparam int unsigned POS_W               = 9;
    localparam int unsigned BYTE_W              = 8;
    localparam int unsigned CRC_W               = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;

    // One received byte held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_stage;

    // Reflected CRC-16/ARC update over one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_arc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int n = 0; n < BYTE_W; n++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/sync_length_frame_receiver.sv -----
// Top level of the length-framed byte receiver with sum and CRC-16/ARC checks.
//
// Takes one received byte per cycle and, while the result port is ready,
// sustains one byte per cycle in both directions. A kept byte passes into
// the input register when accepted, then into the result register, and so
// reaches the result port. The frame state is updated by a single byte-wide
// sum and CRC step between the two registers. While a result waits on the
// result port, the next byte stays in the input register, and the input
// stalls once that register is full. Bytes at the sync positions that are
// not 0xFF are dropped and restart the frame without a result. Every kept
// byte is reported with its position. The last trailer byte sets frame_end,
// and frame_good reports whether the 8-bit sum and the big-endian CRC-16/ARC
// (over the length byte and body) matched.
module sync_length_frame_receiver #(
    parameter int unsigned P_LENGTH_POSITION = slfr_pkg::LENGTH_POSITION_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [slfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_frame_valid,
    input  logic                        i_frame_ready,
    output logic [slfr_pkg::BYTE_W-1:0] o_frame_byte,
    output logic [slfr_pkg::POS_W-1:0]  o_byte_index,
    output logic                        o_frame_end,
    output logic                        o_frame_good
);
    import slfr_pkg::*;

    t_byte_stage stage;
    logic        take;

    slfr_input_stage u_input_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_take     (take),
        .o_stage    (stage)
    );

    slfr_frame_core #(
        .P_LENGTH_POSITION (P_LENGTH_POSITION)
    ) u_frame_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (stage),
        .o_take        (take),
        .o_frame_byte  (o_frame_byte),
        .o_byte_index  (o_byte_index),
        .o_frame_end   (o_frame_end),
        .o_frame_good  (o_frame_good),
        .o_frame_valid (o_frame_valid),
        .i_frame_ready (i_frame_ready)
    );

    // Good is only reported on the closing byte
    a_good_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && o_frame_good |-> o_frame_end)
        else $error("frame_good set on a byte that does not end the frame");

    // A frame cannot close before the length byte and full trailer
    a_end_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && o_frame_end |-> o_byte_index >= POS_W'(P_LENGTH_POSITION + 3))
        else $error("frame closed too early");

    // Sync positions only ever report sync bytes
    a_sync_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && (o_byte_index < POS_W'(P_LENGTH_POSITION))
        |-> o_frame_byte == SYNC_BYTE)
        else $error("non-sync byte reported at a sync position");

endmodule

// ----- rtl/slfr_input_stage.sv -----
// Input register that takes one received byte per cycle, while o_rx_ready is high, from the serial receiver.
module slfr_input_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rx_valid,
    input  logic [slfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_rx_ready,
    input  logic                       i_take,
    output slfr_pkg::t_byte_stage      o_stage
);
    import slfr_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              n_valid;

    // Accept a new transaction when empty or when the held byte moves on
    assign o_rx_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_rx_ready) begin
            n_valid = i_rx_valid;
        end
    end

    // Hold valid under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// ----- rtl/slfr_frame_core.sv -----
// Frame state, sum and CRC checks, and the result register.
module slfr_frame_core #(
    parameter int unsigned P_LENGTH_POSITION = slfr_pkg::LENGTH_POSITION_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slfr_pkg::t_byte_stage       i_stage,
    output logic                        o_take,
    output logic [slfr_pkg::BYTE_W-1:0] o_frame_byte,
    output logic [slfr_pkg::POS_W-1:0]  o_byte_index,
    output logic                        o_frame_end,
    output logic                        o_frame_good,
    output logic                        o_frame_valid,
    input  logic                        i_frame_ready
);
    import slfr_pkg::*;

    localparam logic [POS_W-1:0] LP = POS_W'(P_LENGTH_POSITION);

    // Frame state
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [BYTE_W-1:0] r_len,     n_len;
    logic [BYTE_W-1:0] r_sum,     n_sum;
    logic [CRC_W-1:0]  r_crc,     n_crc;
    logic [BYTE_W-1:0] r_rx_sum,  n_rx_sum;
    logic [BYTE_W-1:0] r_rx_crch, n_rx_crch;

    // Result register
    logic              r_out_vld, n_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_idx;
    logic              r_out_end;
    logic              r_out_good;

    logic [BYTE_W-1:0] b;
    logic              drop;
    logic [BYTE_W-1:0] len_cur;
    logic [POS_W-1:0]  body_end;
    logic              in_body;
    logic              is_end;
    logic              is_good;
    logic              load;

    assign b = i_stage.data;

    // Advance when the result register is free or being drained
    assign o_take = i_stage.valid && (!r_out_vld || i_frame_ready);
    assign drop   = (r_pos < LP) && (b != SYNC_BYTE);
    assign load   = o_take && !drop;

    // Decode the position of this byte within the frame
    always_comb begin
        len_cur  = (r_pos == LP) ? b : r_len;
        body_end = LP + POS_W'(len_cur);
        in_body  = (r_pos >= LP) && (r_pos <= body_end);
        is_end   = (r_pos >= LP + POS_W'(3)) && (r_pos == body_end + POS_W'(3));
        is_good  = (r_sum == r_rx_sum) && (r_crc == {r_rx_crch, b});
    end

    // Next frame state
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_sum     = r_sum;
        n_crc     = r_crc;
        n_rx_sum  = r_rx_sum;
        n_rx_crch = r_rx_crch;
        if (o_take) begin
            if (drop || is_end) begin
                n_pos     = '0;
                n_len     = '0;
                n_sum     = '0;
                n_crc     = '0;
                n_rx_sum  = '0;
                n_rx_crch = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_len = len_cur;
                if (in_body) begin
                    n_sum = r_sum + b;
                    n_crc = crc_arc_byte(r_crc, b);
                end else if (r_pos == body_end + POS_W'(1)) begin
                    n_rx_sum = b;
                end else if (r_pos == body_end + POS_W'(2)) begin
                    n_rx_crch = b;
                end
            end
        end
    end

    // Result valid: set on a kept byte, clear once taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (load) begin
            n_out_vld = 1'b1;
        end else if (i_frame_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_crc     <= '0;
            r_rx_sum  <= '0;
            r_rx_crch <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_sum     <= n_sum;
            r_crc     <= n_crc;
            r_rx_sum  <= n_rx_sum;
            r_rx_crch <= n_rx_crch;
            r_out_vld <= n_out_vld;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= b;
            r_out_idx  <= r_pos;
            r_out_end  <= is_end;
            r_out_good <= is_end && is_good;
        end
    end

    assign o_frame_valid = r_out_vld;
    assign o_frame_byte  = r_out_byte;
    assign o_byte_index  = r_out_idx;
    assign o_frame_end   = r_out_end;
    assign o_frame_good  = r_out_good;

endmodule
